// ===== rtl/llpr_pkg.sv =====
// Shared constants, opcodes, FSM state type and control structs for the
// least-loaded partition reassignment block. No dependencies.
package llpr_pkg;

  localparam int MAX_PARTS = 16;
  localparam int LOAD_BITS = 48;
  localparam int PART_BITS = $clog2(MAX_PARTS);
  localparam int CNT_BITS  = $clog2(MAX_PARTS + 1);
  localparam int VID_BITS  = 32;
  localparam int DEG_BITS  = 20;
  localparam int OP_BITS   = 2;

  // stream payload widths
  localparam int S_DATA_BITS = 56;  // vertex_id, vertex_degree, initial_part
  localparam int M_DATA_BITS = 40;  // result_vertex, assigned_part, zero pad

  localparam logic [OP_BITS-1:0] OP_ACCUMULATE = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ASSIGN     = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR      = 2'd2;

  localparam logic [CNT_BITS-1:0] ACTIVE_RESET = CNT_BITS'(MAX_PARTS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD_INIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_MOVE_OLD,
    ST_MOVE_NEW,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take_item;  // latch the accepted transfer
    logic clear;      // zero all loads
    logic rd_init;    // read load of initial partition
    logic take_init;  // seed min search with that load
    logic scan_rd;    // read load at scan index, advance index
    logic wr_acc;     // init load += degree
    logic wr_old;     // init load -= degree
    logic wr_new;     // best load += degree
    logic out_load;   // push result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               in_range;
    logic               scan_last;
    logic               moved;
    logic               out_free;
  } dp_status_t;

endpackage

// ===== rtl/least_loaded_partition_reassign.sv =====
// One item at a time: s_tready is high only while idle, so each item runs to
// completion before the next is taken. An assign scans the active partitions
// through the single-read-port load memory, one partition per cycle, before
// its result is loaded.
// Reset (rst, synchronous): loads read as zero, active count 16, no result.
// Depends on llpr_pkg, llpr_ctrl, llpr_datapath.
module least_loaded_partition_reassign import llpr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_DATA_BITS-1:0] s_tdata,   // vertex_id[31:0], vertex_degree[51:32],
                                            // initial_part[55:52]
  input  logic [OP_BITS-1:0]     s_tuser,   // operation[1:0]
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_DATA_BITS-1:0] m_tdata,   // result_vertex[31:0], assigned_part[35:32],
                                            // zero[39:36]
  output logic [0:0]             m_tuser,   // part_error[0]
  // active_partitions register
  input  logic                   cfg_we,
  input  logic [CNT_BITS-1:0]    cfg_data
);

  // Controller walks each item through decode and, as its operation needs,
  // load read, scan and move; datapath owns all storage and arithmetic.
  dp_cmd_t    cmd;
  dp_status_t status;

  llpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Load memory is 16 x 48 with per-entry valid bits; a clear transfer
  // drops all valid bits at once. The output register lets the next
  // transfer be taken while a result still waits on m_tready.
  llpr_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== rtl/llpr_ctrl.sv =====
// Controller FSM: sequences decode, load read, partition scan, load move
// and result hand-off. Depends on llpr_pkg.
module llpr_ctrl import llpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.op)
          OP_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end
          OP_ACCUMULATE: begin
            if (status.in_range) begin
              cmd.rd_init = 1'b1;
              state_next  = ST_LOAD_INIT;
            end else begin
              state_next = ST_IDLE;
            end
          end
          OP_ASSIGN: begin
            if (status.in_range) begin
              cmd.rd_init = 1'b1;
              state_next  = ST_LOAD_INIT;
            end else begin
              state_next = ST_OUT;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_LOAD_INIT: begin
        cmd.take_init = 1'b1;
        if (status.op == OP_ACCUMULATE) begin
          cmd.wr_acc = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_next = ST_MOVE_OLD;
      end
      ST_MOVE_OLD: begin
        if (status.moved) begin
          cmd.wr_old = 1'b1;
          state_next = ST_MOVE_NEW;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_MOVE_NEW: begin
        cmd.wr_new = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/llpr_datapath.sv =====
// Datapath: item registers, load memory with valid bits, min-load compare,
// saturating update and output register. Depends on llpr_pkg.
module llpr_datapath import llpr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  logic [S_DATA_BITS-1:0] s_tdata,
  input  logic [OP_BITS-1:0]     s_tuser,
  input  logic                   cfg_we,
  input  logic [CNT_BITS-1:0]    cfg_data,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_DATA_BITS-1:0] m_tdata,
  output logic [0:0]             m_tuser
);

  localparam logic [LOAD_BITS-1:0] LOAD_MAX = '1;

  // item registers
  logic [OP_BITS-1:0]   op;
  logic [VID_BITS-1:0]  vid;
  logic [DEG_BITS-1:0]  deg;
  logic [PART_BITS-1:0] init;
  logic [CNT_BITS-1:0]  active;

  // search registers
  logic [LOAD_BITS-1:0] min_load;
  logic [LOAD_BITS-1:0] init_load;
  logic [PART_BITS-1:0] best;
  logic [PART_BITS-1:0] scan_idx;
  logic [PART_BITS-1:0] rd_idx;
  logic                 scan_vld;

  // load memory
  logic [LOAD_BITS-1:0] mem [MAX_PARTS];
  logic [MAX_PARTS-1:0] valid;
  logic [LOAD_BITS-1:0] rd_raw;
  logic                 rd_valid;
  logic [LOAD_BITS-1:0] rdata;
  logic [PART_BITS-1:0] rd_addr;
  logic                 rd_en;
  logic                 wr_en;
  logic [PART_BITS-1:0] wr_addr;
  logic [LOAD_BITS-1:0] wr_data;

  logic [CNT_BITS-1:0]  eff_count;
  logic                 in_range;

  function automatic logic [LOAD_BITS-1:0] sat_add(input logic [LOAD_BITS-1:0] a,
                                                   input logic [DEG_BITS-1:0]  d);
    logic [LOAD_BITS:0] s;
    s = {1'b0, a} + (LOAD_BITS+1)'(d);
    return s[LOAD_BITS] ? LOAD_MAX : s[LOAD_BITS-1:0];
  endfunction

  function automatic logic [LOAD_BITS-1:0] floor_sub(input logic [LOAD_BITS-1:0] a,
                                                     input logic [DEG_BITS-1:0]  d);
    logic [LOAD_BITS-1:0] dw;
    dw = LOAD_BITS'(d);
    return (dw > a) ? '0 : a - dw;
  endfunction

  // register values above MAX_PARTS act as MAX_PARTS
  assign eff_count = (active > CNT_BITS'(MAX_PARTS)) ? CNT_BITS'(MAX_PARTS) : active;
  assign in_range  = {1'b0, init} < eff_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      op   <= s_tuser;
      vid  <= s_tdata[VID_BITS-1:0];
      deg  <= s_tdata[VID_BITS+DEG_BITS-1:VID_BITS];
      init <= s_tdata[VID_BITS+DEG_BITS+PART_BITS-1:VID_BITS+DEG_BITS];
      best <= s_tdata[VID_BITS+DEG_BITS+PART_BITS-1:VID_BITS+DEG_BITS];
    end else if (cmd.take_init) begin
      best <= init;
    end else if (scan_vld && (rdata < min_load)) begin
      best <= rd_idx;
    end
    if (cmd.take_init) begin
      min_load  <= rdata;
      init_load <= rdata;
    end else if (scan_vld && (rdata < min_load)) begin
      min_load <= rdata;
    end
    if (cmd.take_init) begin
      scan_idx <= '0;
    end else if (cmd.scan_rd) begin
      scan_idx <= scan_idx + 1'b1;
    end
    rd_idx <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_vld <= 1'b0;
    end else begin
      scan_vld <= cmd.scan_rd;
    end
  end

  // memory ports
  assign rd_en   = cmd.rd_init | cmd.scan_rd;
  assign rd_addr = cmd.scan_rd ? scan_idx : init;
  assign wr_en   = cmd.wr_acc | cmd.wr_old | cmd.wr_new;
  assign wr_addr = cmd.wr_new ? best : init;

  always_comb begin
    if (cmd.wr_acc) begin
      wr_data = sat_add(rdata, deg);
    end else if (cmd.wr_old) begin
      wr_data = floor_sub(init_load, deg);
    end else begin
      wr_data = sat_add(min_load, deg);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw   <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // never-written entries read as zero
  assign rdata = rd_valid ? rd_raw : '0;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {(M_DATA_BITS-VID_BITS-PART_BITS)'(0), best, vid};
      m_tuser <= ~in_range;
    end
  end

  assign status.op        = op;
  assign status.in_range  = in_range;
  assign status.scan_last = ({1'b0, scan_idx} == (eff_count - 1'b1));
  assign status.moved     = (best != init);
  assign status.out_free  = ~m_tvalid | m_tready;

endmodule

// ===== rtl/llpr_checker.sv =====
// Port-level checker for least_loaded_partition_reassign, bound to the top.
// Depends on llpr_pkg.
module llpr_checker import llpr_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [M_DATA_BITS-1:0] m_tdata,
  input logic [0:0]             m_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // one item at a time: busy right after a transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after transfer");

  // a new result is only loaded while the block is busy
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without an item in flight");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind least_loaded_partition_reassign llpr_checker u_llpr_checker (.*);

// ===== tb/tb_least_loaded_partition_reassign.sv =====
// Self-checking testbench for least_loaded_partition_reassign: a directed table, then
// randomized phases under several active-partition settings, scored by a predictor or table.
// Depends on llpr_pkg and the RTL top level only.
module tb_least_loaded_partition_reassign;
  import llpr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Operation code the block must ignore
  localparam logic [OP_BITS-1:0] OP_UNKNOWN = 2'd3;
  // Settle time before a register write: covers the longest assign with margin
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RAND_PHASES = 8;

  typedef struct packed {
    logic [VID_BITS-1:0]  vid;
    logic [PART_BITS-1:0] part;
    logic                 err;
  } placement_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // One line of the directed script. Register rows carry only cfg_val.
  // Rows with typed set carry an expected result that is obvious by inspection.
  typedef struct packed {
    row_kind_t            kind;
    logic [CNT_BITS-1:0]  cfg_val;
    logic [OP_BITS-1:0]   op;
    logic [VID_BITS-1:0]  vid;
    logic [DEG_BITS-1:0]  deg;
    logic [PART_BITS-1:0] init;
    bit                   typed;
    logic [PART_BITS-1:0] exp_part;
    logic                 exp_err;
  } drow_t;

  localparam drow_t DIRECTED [0:22] = '{
    // zero loads: assign keeps its own partition, all-ones fields
    '{ROW_ITEM, 5'd0,  OP_ASSIGN,     32'hFFFF_FFFF, 20'hFFFFF, 4'd15, 1'b1, 4'd15, 1'b0},
    '{ROW_ITEM, 5'd0,  OP_ACCUMULATE, 32'h0000_0000, 20'hFFFFF, 4'd0,  1'b0, 4'd0,  1'b0},
    '{ROW_ITEM, 5'd0,  OP_ACCUMULATE, 32'h0000_0001, 20'd5,     4'd3,  1'b0, 4'd0,  1'b0},
    // move with degree above the old load: old load floors at zero
    '{ROW_ITEM, 5'd0,  OP_ASSIGN,     32'h0000_0010, 20'd1000,  4'd3,  1'b0, 4'd0,  1'b0},
    // move with zero degree
    '{ROW_ITEM, 5'd0,  OP_ASSIGN,     32'h0000_0011, 20'd0,     4'd0,  1'b0, 4'd0,  1'b0},
    '{ROW_ITEM, 5'd0,  OP_UNKNOWN,    32'h1234_5678, 20'hFFFFF, 4'd15, 1'b0, 4'd0,  1'b0},
    '{ROW_ITEM, 5'd0,  OP_CLEAR,      32'h0000_0000, 20'd0,     4'd0,  1'b0, 4'd0,  1'b0},
    '{ROW_ITEM, 5'd0,  OP_ASSIGN,     32'h0000_0020, 20'd1,     4'd7,  1'b1, 4'd7,  1'b0},
    // single partition: everything above zero is out of range
    '{ROW_CFG,  5'd1,  OP_CLEAR,      32'h0000_0000, 20'd0,     4'd0,  1'b0, 4'd0,  1'b0},
    '{ROW_ITEM, 5'd0,  OP_ASSIGN,     32'h0000_0000, 20'd0,     4'd0,  1'b1, 4'd0,  1'b0},
    '{ROW_ITEM, 5'd0,  OP_ASSIGN,     32'h0000_0001, 20'd2,     4'd1,  1'b1, 4'd1,  1'b1},
    '{ROW_ITEM, 5'd0,  OP_ACCUMULATE, 32'h0000_0002, 20'hFFFFF, 4'd15, 1'b0, 4'd0,  1'b0},
    '{ROW_ITEM, 5'd0,  OP_ASSIGN,     32'hA5A5_A5A5, 20'd3,     4'd15, 1'b1, 4'd15, 1'b1},
    // zero active count: every item is out of range
    '{ROW_CFG,  5'd0,  OP_CLEAR,      32'h0000_0000, 20'd0,     4'd0,  1'b0, 4'd0,  1'b0},
    '{ROW_ITEM, 5'd0,  OP_ASSIGN,     32'h5A5A_5A5A, 20'd9,     4'd0,  1'b1, 4'd0,  1'b1},
    '{ROW_ITEM, 5'd0,  OP_ACCUMULATE, 32'h0000_0003, 20'd7,     4'd0,  1'b0, 4'd0,  1'b0},
    // count above the partition total acts as the total
    '{ROW_CFG,  5'd31, OP_CLEAR,      32'h0000_0000, 20'd0,     4'd0,  1'b0, 4'd0,  1'b0},
    '{ROW_ITEM, 5'd0,  OP_ASSIGN,     32'h0000_0040, 20'd3,     4'd15, 1'b1, 4'd15, 1'b0},
    '{ROW_ITEM, 5'd0,  OP_ACCUMULATE, 32'h0000_0004, 20'd100,   4'd0,  1'b0, 4'd0,  1'b0},
    '{ROW_ITEM, 5'd0,  OP_ACCUMULATE, 32'h0000_0005, 20'd50,    4'd2,  1'b0, 4'd0,  1'b0},
    '{ROW_ITEM, 5'd0,  OP_ASSIGN,     32'h0000_0050, 20'd30,    4'd0,  1'b0, 4'd0,  1'b0},
    '{ROW_ITEM, 5'd0,  OP_ASSIGN,     32'h0000_0051, 20'd30,    4'd2,  1'b0, 4'd0,  1'b0},
    '{ROW_CFG,  5'd16, OP_CLEAR,      32'h0000_0000, 20'd0,     4'd0,  1'b0, 4'd0,  1'b0}
  };

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_DATA_BITS-1:0] s_tdata;
  logic [OP_BITS-1:0]     s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [M_DATA_BITS-1:0] m_tdata;
  logic [0:0]             m_tuser;
  logic                   cfg_we;
  logic [CNT_BITS-1:0]    cfg_data;

  least_loaded_partition_reassign u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Predictor state: mirrors the load table and the active-count register
  logic [LOAD_BITS-1:0] part_load [MAX_PARTS];
  logic [CNT_BITS-1:0]  active_reg;

  placement_t placement_q [$];  // expected results, oldest first
  placement_t want;
  int         fault_cnt;
  bit         calm;             // final phase: no idling on either side
  bit         hold_req;         // asks the receiver for one long hold-off

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: far above the slowest legal run
  initial begin
    #3ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Append one expected result at the tail of the queue
  function automatic void queue_expect(input placement_t r);
    placement_q.insert(placement_q.size(), r);
  endfunction

  function automatic logic [LOAD_BITS-1:0] load_plus(input logic [LOAD_BITS-1:0] a,
                                                     input logic [DEG_BITS-1:0] d);
    logic [LOAD_BITS:0] s;
    s = {1'b0, a} + d;
    return s[LOAD_BITS] ? {LOAD_BITS{1'b1}} : s[LOAD_BITS-1:0];
  endfunction

  function automatic int eff_count();
    return (active_reg > MAX_PARTS) ? MAX_PARTS : int'(active_reg);
  endfunction

  // Greedy least-loaded placement; updates the load table, returns 1 if a result is due
  function automatic bit place_vertex(input logic [OP_BITS-1:0] op,
                                      input logic [VID_BITS-1:0] vid,
                                      input logic [DEG_BITS-1:0] deg,
                                      input logic [PART_BITS-1:0] init,
                                      output placement_t res);
    int                   count;
    bit                   in_range;
    int                   best;
    logic [LOAD_BITS-1:0] min_load;
    count = eff_count();
    in_range = int'(init) < count;
    res = '0;
    case (op)
      OP_CLEAR: begin
        foreach (part_load[i]) part_load[i] = '0;
        return 1'b0;
      end
      OP_ACCUMULATE: begin
        if (in_range) part_load[init] = load_plus(part_load[init], deg);
        return 1'b0;
      end
      OP_ASSIGN: begin
        best = int'(init);
        if (in_range) begin
          min_load = part_load[init];
          for (int p = 0; p < count; p++) begin
            if (part_load[p] < min_load) begin
              best = p;
              min_load = part_load[p];
            end
          end
          if (best != int'(init)) begin
            // old load floors at zero, new load saturates
            part_load[init] = (deg > part_load[init]) ? '0 : part_load[init] - deg;
            part_load[best] = load_plus(part_load[best], deg);
          end
        end
        res.vid  = vid;
        res.part = PART_BITS'(best);
        res.err  = !in_range;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Drop valid and stay off; n sets the length of the pause
  task automatic hold_sender(input int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Offer one item, wait for the transfer, then run the predictor on it
  task automatic offer_item(input logic [OP_BITS-1:0] op, input logic [VID_BITS-1:0] vid,
                            input logic [DEG_BITS-1:0] deg, input logic [PART_BITS-1:0] init,
                            output bit due, output placement_t res);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {init, deg, vid};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    due = place_vertex(op, vid, deg, init, res);
  endtask

  // Block idle: all results in, and time for a trailing accumulate or clear to retire
  task automatic settle_block();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (placement_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active(input logic [CNT_BITS-1:0] v);
    settle_block();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_reg = v;
  endtask

  // Random item shaped for the current active count: mostly in range, mixed degree sizes
  task automatic pick_item(output logic [OP_BITS-1:0] op, output logic [VID_BITS-1:0] vid,
                           output logic [DEG_BITS-1:0] deg, output logic [PART_BITS-1:0] init);
    int cnt;
    int r;
    cnt = eff_count();
    r = $urandom_range(99, 0);
    if (r < 45)      op = OP_ASSIGN;
    else if (r < 93) op = OP_ACCUMULATE;
    else if (r < 97) op = OP_CLEAR;
    else             op = OP_UNKNOWN;
    vid = $urandom;
    r = $urandom_range(9, 0);
    if (r < 3)      deg = DEG_BITS'($urandom_range(15, 0));
    else if (r < 8) deg = DEG_BITS'($urandom_range(4095, 0));
    else            deg = DEG_BITS'($urandom);
    if ($urandom_range(9, 0) != 0 && cnt > 0)
      init = PART_BITS'($urandom_range(cnt - 1, 0));
    else if (cnt < MAX_PARTS)
      init = PART_BITS'($urandom_range(MAX_PARTS - 1, cnt));
    else
      init = PART_BITS'($urandom_range(MAX_PARTS - 1, 0));
  endtask

  // Receiver: random ready/stall bursts, one long hold-off on request, steady ready when calm
  initial begin
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      if (calm) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(3, 0) != 0);
        repeat ($urandom_range(19, 1)) @(posedge clk);
      end
    end
  end

  // Scoreboard: every result transfer is matched against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (placement_q.size() == 0) begin
        $error("result_vertex %h arrived with no result pending", m_tdata[31:0]);
        fault_cnt++;
      end else begin
        want = placement_q.pop_front();
        if (m_tdata[31:0] !== want.vid) begin
          $error("result_vertex: expected %h, actual %h", want.vid, m_tdata[31:0]);
          fault_cnt++;
        end
        if (m_tdata[35:32] !== want.part) begin
          $error("assigned_part: expected %0d, actual %0d", want.part, m_tdata[35:32]);
          fault_cnt++;
        end
        if (m_tuser[0] !== want.err) begin
          $error("part_error: expected %0d, actual %0d", want.err, m_tuser[0]);
          fault_cnt++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [OP_BITS-1:0]   op;
    logic [VID_BITS-1:0]  vid;
    logic [DEG_BITS-1:0]  deg;
    logic [PART_BITS-1:0] init;
    bit                   due;
    placement_t           res;
    placement_t           typed_res;
    logic [CNT_BITS-1:0]  phase_cfg [RAND_PHASES];
    int                   phase_len;

    fault_cnt = 0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= OP_ACCUMULATE;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    foreach (part_load[i]) part_load[i] = '0;
    active_reg = ACTIVE_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed script
    foreach (DIRECTED[k]) begin
      if (DIRECTED[k].kind == ROW_CFG) begin
        write_active(DIRECTED[k].cfg_val);
      end else begin
        offer_item(DIRECTED[k].op, DIRECTED[k].vid, DIRECTED[k].deg, DIRECTED[k].init,
                   due, res);
        if (due && DIRECTED[k].typed) begin
          typed_res.vid  = DIRECTED[k].vid;
          typed_res.part = DIRECTED[k].exp_part;
          typed_res.err  = DIRECTED[k].exp_err;
          queue_expect(typed_res);
        end else if (due) begin
          queue_expect(res);
        end
        if ($urandom_range(2, 0) == 0) hold_sender($urandom_range(19, 1));
      end
    end

    // Random phases: full, single, zero, oversized, two mid counts, oversized again, full
    phase_cfg[0] = 5'd16;
    phase_cfg[1] = 5'd1;
    phase_cfg[2] = 5'd0;
    phase_cfg[3] = 5'd31;
    phase_cfg[4] = CNT_BITS'($urandom_range(15, 2));
    phase_cfg[5] = CNT_BITS'($urandom_range(15, 2));
    phase_cfg[6] = CNT_BITS'($urandom_range(30, 17));
    phase_cfg[7] = 5'd16;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_active(phase_cfg[ph]);
      phase_len = (phase_cfg[ph] == 0) ? 40 : 110;
      if (ph == RAND_PHASES - 1) calm = 1'b1;
      // long receiver hold-off while items keep coming: fills the block, stalls input
      if (ph == 4) hold_req = 1'b1;
      for (int n = 0; n < phase_len; n++) begin
        pick_item(op, vid, deg, init);
        offer_item(op, vid, deg, init, due, res);
        if (due) queue_expect(res);
        if (ph == 5 && n == phase_len / 2) begin
          // sender pauses until the result stream has fully drained
          s_tvalid <= 1'b0;
          @(posedge clk);
          while (placement_q.size() != 0) @(posedge clk);
        end else if (!calm && $urandom_range(3, 0) == 0) begin
          hold_sender($urandom_range(19, 1));
        end
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (placement_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
